@@ hw/rtl/sld_pkg.sv @@
// Shared types and constants of the sync/length deframer.
package sld_pkg;

   // frame phase, one-hot
   typedef enum logic [2:0] {
      PHASE_HUNT    = 3'b001,
      PHASE_HEADER  = 3'b010,
      PHASE_PAYLOAD = 3'b100
   } phase_type;

   // configuration register indexes
   localparam logic CSR_BYTE_ORDER  = 1'b0;
   localparam logic CSR_MAX_PAYLOAD = 1'b1;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65535;

   // sync sequence AA 44 12
   localparam logic [15:0] SYNC_PREFIX = 16'hAA44;
   localparam logic [7:0]  SYNC_FINAL  = 8'h12;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       frame_last;
      logic       frame_empty;
      logic       length_error;
   } rsp_type;

endpackage

@@ hw/rtl/sync_length_deframer.sv @@
// Sync-word hunt, length-prefixed header parse and payload pass-through.
// Results are held in the output register, or in the skid entry under rsp_stall.
// Throughput: one request per cycle while req_stall is low; the per-byte decode
// is one pass of logic between the frame state registers and a two-entry output
// register/skid pair. req_stall rises only while the skid entry is full.
// Reset (synchronous, active high) returns to hunting with empty output stage.
module sync_length_deframer
   import sld_pkg::*;
#(
   parameter int LENGTH_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_last,
   output logic        rsp_frame_empty,
   output logic        rsp_length_error,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int CNT_W = $clog2(LENGTH_BYTES + 2);
   localparam int K_W   = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
   localparam logic [CNT_W-1:0] HDR_DONE = CNT_W'(LENGTH_BYTES + 1);

   logic        big_endian_ff;
   logic [31:0] max_payload_ff;

   phase_type        phase_ff, phase_in;
   logic [15:0]      recent_ff, recent_in;
   logic [CNT_W-1:0] hcount_ff, hcount_in;
   logic [31:0]      gather_ff, gather_in;
   logic [31:0]      remain_ff, remain_in;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   logic             accept;
   logic             produce;
   logic             pop;
   rsp_type          result;
   logic [CNT_W-1:0] hcount_inc;
   logic [K_W-1:0]   kpos;
   logic [31:0]      gathered;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign pop       = main_valid_ff && !rsp_stall;

   assign rsp_payload_byte = main_ff.payload_byte;
   assign rsp_frame_last   = main_ff.frame_last;
   assign rsp_frame_empty  = main_ff.frame_empty;
   assign rsp_length_error = main_ff.length_error;

   assign hcount_inc = hcount_ff + 1'b1;
   assign kpos       = K_W'(hcount_ff - 1'b1);

   // fold in one length byte; the reserved byte (count zero) adds nothing
   always_comb begin
      gathered = gather_ff;
      if (hcount_ff != '0) begin
         if (big_endian_ff) begin
            gathered = {gather_ff[23:0], req_rx_byte};
         end else begin
            gathered = gather_ff | ({24'd0, req_rx_byte} << {kpos, 3'b000});
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      recent_in = recent_ff;
      hcount_in = hcount_ff;
      gather_in = gather_ff;
      remain_in = remain_ff;
      produce   = 1'b0;
      result    = '0;
      if (accept) begin
         unique case (phase_ff)
            PHASE_HEADER: begin
               hcount_in = hcount_inc;
               gather_in = gathered;
               if (hcount_inc == HDR_DONE) begin
                  hcount_in = '0;
                  gather_in = '0;
                  priority if (gathered == 32'd0) begin
                     produce            = 1'b1;
                     result.frame_last  = 1'b1;
                     result.frame_empty = 1'b1;
                     phase_in           = PHASE_HUNT;
                     recent_in          = '0;
                     remain_in          = '0;
                  end else if (gathered > max_payload_ff) begin
                     produce             = 1'b1;
                     result.frame_last   = 1'b1;
                     result.length_error = 1'b1;
                     phase_in            = PHASE_HUNT;
                     recent_in           = '0;
                     remain_in           = '0;
                  end else begin
                     phase_in  = PHASE_PAYLOAD;
                     remain_in = gathered;
                  end
               end
            end
            PHASE_PAYLOAD: begin
               produce             = 1'b1;
               result.payload_byte = req_rx_byte;
               if (remain_ff <= 32'd1) begin
                  result.frame_last = 1'b1;
                  phase_in          = PHASE_HUNT;
                  recent_in         = '0;
                  hcount_in         = '0;
                  gather_in         = '0;
                  remain_in         = '0;
               end else begin
                  remain_in = remain_ff - 32'd1;
               end
            end
            default: begin
               if (recent_ff == SYNC_PREFIX && req_rx_byte == SYNC_FINAL) begin
                  phase_in  = PHASE_HEADER;
                  recent_in = '0;
                  hcount_in = '0;
                  gather_in = '0;
                  remain_in = '0;
               end else begin
                  phase_in  = PHASE_HUNT;
                  recent_in = {recent_ff[7:0], req_rx_byte};
               end
            end
         endcase
      end
   end

   // output register with skid entry; push never meets a full skid
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (produce) begin
            main_in       = result;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (produce) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff  <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
         phase_ff       <= PHASE_HUNT;
         recent_ff      <= '0;
         hcount_ff      <= '0;
         gather_ff      <= '0;
         remain_ff      <= '0;
         main_valid_ff  <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_BYTE_ORDER:  big_endian_ff  <= csr_data[0];
               CSR_MAX_PAYLOAD: max_payload_ff <= csr_data;
               default: ;
            endcase
         end
         phase_ff      <= phase_in;
         recent_ff     <= recent_in;
         hcount_ff     <= hcount_in;
         gather_ff     <= gather_in;
         remain_ff     <= remain_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
